[design/sgpg_pkg.sv]
package sgpg_pkg;

  localparam int STEP_W     = 10;
  localparam int RADIUS_W   = 24;
  localparam int POS_W      = 25;
  localparam int IDX_OUT_W  = 10;
  localparam int MAG_W      = 16;
  localparam int FRAC_W     = 30;
  localparam int Q_W        = 31;
  localparam int MUL_DIGIT  = 4;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int XY_SHIFT   = 30;
  localparam int Z_SHIFT    = 15;
  localparam int MAG_SHIFT  = 15;

  localparam logic [1:0] REG_POLAR_STEPS   = 2'd0;
  localparam logic [1:0] REG_AZIMUTH_STEPS = 2'd1;
  localparam logic [1:0] REG_SPHERE_RADIUS = 2'd2;

  localparam logic [STEP_W-1:0]   POLAR_STEPS_RST   = 10'd10;
  localparam logic [STEP_W-1:0]   AZIMUTH_STEPS_RST = 10'd10;
  localparam logic [RADIUS_W-1:0] SPHERE_RADIUS_RST = 24'd6371000;

  localparam logic [Q_W-1:0]   Q30_ONE  = 31'h4000_0000;
  localparam logic [MAG_W-1:0] MAG_ONE  = 16'h8000;
  localparam logic [31:0]      MAG_HALF = 32'd16384;

  // odd polynomial for sin(z*pi/2), Q30, Horner order c0 - z2*(c1 - z2*(...))
  localparam logic [Q_W-1:0] POLY_C4 = 31'd172272;
  localparam logic [Q_W-1:0] POLY_COEF [4] = '{
    31'd1686629713, 31'd693598669, 31'd85569305, 31'd5026995
  };

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sine_res_t;

  typedef enum logic [1:0] {
    SN_IDLE,
    SN_SQUARE,
    SN_HORNER,
    SN_FINAL
  } sine_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_POL,
    ST_DIV_AZ,
    ST_DIV_WRAP,
    ST_SINE,
    ST_SCALE,
    ST_OUT
  } gen_state_t;

endpackage

[design/sgpg_div.sv]
module sgpg_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 10,
  parameter int QUO_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // restoring division, one quotient bit per cycle; quotient shifts in behind the numerator
  always_comb begin
    trial    = {rem_r, num_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = num_r[QUO_W-1:0];
  assign rem  = rem_r;

endmodule

[design/sgpg_mul.sv]
module sgpg_mul #(
  parameter int A_W = 31,
  parameter int B_W = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int DIG   = sgpg_pkg::MUL_DIGIT;
  localparam int NDIG  = (B_W + DIG - 1) / DIG;
  localparam int BP_W  = NDIG * DIG;
  localparam int ACC_W = A_W + BP_W;
  localparam int CNT_W = $clog2(NDIG + 1);

  logic [A_W-1:0]     a_r, a_nxt;
  logic [BP_W-1:0]    b_r, b_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [A_W+DIG-1:0] pp;

  // MSB-first, one digit of b per cycle
  always_comb begin
    pp       = a_r * b_r[BP_W-1 -: DIG];
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = BP_W'(b);
      acc_nxt  = '0;
      cnt_nxt  = CNT_W'(NDIG);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = (acc_r << DIG) + ACC_W'(pp);
      b_nxt   = b_r << DIG;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r[A_W+B_W-1:0];

endmodule

[design/sgpg_sine.sv]
module sgpg_sine #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic                  done,
  output sgpg_pkg::sine_res_t   res
);

  localparam int QW  = sgpg_pkg::Q_W;
  localparam int FW  = sgpg_pkg::FRAC_W;
  localparam int PW  = 2 * QW;
  localparam int PAD = 32 - ANGLE_BITS;

  sgpg_pkg::sine_state_t state_r, state_nxt;

  logic                      launch_r, launch_nxt;
  logic                      done_r, done_nxt;
  logic [1:0]                k_r, k_nxt;
  logic [QW-1:0]             z_r, z_nxt;
  logic [QW-1:0]             z2_r, z2_nxt;
  logic [QW-1:0]             t_r, t_nxt;
  logic                      neg_r, neg_nxt;
  logic [sgpg_pkg::MAG_W-1:0] mag_r, mag_nxt;
  logic [QW-2:0]             zq;
  logic [QW-1:0]             mul_a, mul_b;
  logic                      mul_start, mul_done;
  logic [PW-1:0]             mul_prod;
  logic [QW-1:0]             prod_q;
  logic [31:0]               s_rnd;
  logic [16:0]               m_full;

  sgpg_mul #(
    .A_W(QW),
    .B_W(QW)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sgpg_pkg::SN_IDLE: begin
        if (start) state_nxt = sgpg_pkg::SN_SQUARE;
      end
      sgpg_pkg::SN_SQUARE: begin
        if (mul_done) state_nxt = sgpg_pkg::SN_HORNER;
      end
      sgpg_pkg::SN_HORNER: begin
        if (mul_done && k_r == 2'd0) state_nxt = sgpg_pkg::SN_FINAL;
      end
      sgpg_pkg::SN_FINAL: begin
        if (mul_done) state_nxt = sgpg_pkg::SN_IDLE;
      end
      default: state_nxt = sgpg_pkg::SN_IDLE;
    endcase
  end

  always_comb begin
    mul_start = launch_r;
    case (state_r)
      sgpg_pkg::SN_SQUARE: begin
        mul_a = z_r;
        mul_b = z_r;
      end
      sgpg_pkg::SN_HORNER: begin
        mul_a = t_r;
        mul_b = z2_r;
      end
      sgpg_pkg::SN_FINAL: begin
        mul_a = t_r;
        mul_b = z_r;
      end
      default: begin
        mul_a = z_r;
        mul_b = z_r;
      end
    endcase
  end

  always_comb begin
    zq         = {angle[ANGLE_BITS-3:0], {PAD{1'b0}}};
    prod_q     = mul_prod[FW+QW-1:FW];
    s_rnd      = {1'b0, prod_q} + sgpg_pkg::MAG_HALF;
    m_full     = s_rnd[31:sgpg_pkg::MAG_SHIFT];
    launch_nxt = 1'b0;
    done_nxt   = 1'b0;
    k_nxt      = k_r;
    z_nxt      = z_r;
    z2_nxt     = z2_r;
    t_nxt      = t_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    if (state_r == sgpg_pkg::SN_IDLE && start) begin
      // fold into first quadrant
      z_nxt      = angle[ANGLE_BITS-2] ? (sgpg_pkg::Q30_ONE - {1'b0, zq}) : {1'b0, zq};
      neg_nxt    = angle[ANGLE_BITS-1];
      launch_nxt = 1'b1;
    end
    if (mul_done) begin
      case (state_r)
        sgpg_pkg::SN_SQUARE: begin
          z2_nxt     = prod_q;
          t_nxt      = sgpg_pkg::POLY_C4;
          k_nxt      = 2'd3;
          launch_nxt = 1'b1;
        end
        sgpg_pkg::SN_HORNER: begin
          t_nxt      = sgpg_pkg::POLY_COEF[k_r] - prod_q;
          k_nxt      = k_r - 2'd1;
          launch_nxt = 1'b1;
        end
        sgpg_pkg::SN_FINAL: begin
          mag_nxt  = (m_full > 17'(sgpg_pkg::MAG_ONE)) ? sgpg_pkg::MAG_ONE
                                                      : m_full[sgpg_pkg::MAG_W-1:0];
          done_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sgpg_pkg::SN_IDLE;
      launch_r <= 1'b0;
      done_r   <= 1'b0;
      k_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= launch_nxt;
      done_r   <= done_nxt;
      k_r      <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r   <= z_nxt;
    z2_r  <= z2_nxt;
    t_r   <= t_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
  end

  assign done    = done_r;
  assign res.neg = neg_r;
  assign res.mag = mag_r;

endmodule

[design/sphere_grid_point_generator.sv]
// Latitude/longitude grid point generator. Each request produces the next grid point on a
// sphere of radius sphere_radius as rounded x/y/z metres, together with the polar and
// azimuth indices used; the polar index steps first and wraps to 0 past polar_steps, then
// the azimuth index advances modulo azimuth_steps, and restart=1 zeroes both before the
// point is made. One request is worked on at a time, and a finished point waits in the
// output register while the next request is taken. A new request is accepted only once
// the previous one is through, and later while the previous point still waits in the
// output register. Each request takes three passes of the bit-serial divider (two angles
// and the azimuth wrap), four sine evaluations of six 4-bit-digit serial products each,
// four radius products, an output state and an idle state.
module sphere_grid_point_generator #(
  parameter int ANGLE_BITS = 16,
  parameter int INDEX_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sgpg_pkg::POS_W-1:0]   out_x_pos,
  output logic signed [sgpg_pkg::POS_W-1:0]   out_y_pos,
  output logic signed [sgpg_pkg::POS_W-1:0]   out_z_pos,
  output logic [sgpg_pkg::IDX_OUT_W-1:0]      out_polar_index_out,
  output logic [sgpg_pkg::IDX_OUT_W-1:0]      out_azimuth_index_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sgpg_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [sgpg_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sgpg_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int SW    = sgpg_pkg::STEP_W;
  localparam int RW    = sgpg_pkg::RADIUS_W;
  localparam int MW    = sgpg_pkg::MAG_W;
  localparam int PW    = sgpg_pkg::POS_W;
  localparam int NUM_W = INDEX_BITS + ANGLE_BITS;
  localparam int CMP_W = (INDEX_BITS + 1 > SW) ? INDEX_BITS + 1 : SW;
  localparam int RS_W  = RW + MW;
  localparam int SC_W  = RS_W + MW;
  localparam logic [ANGLE_BITS-1:0] ANG_QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

  sgpg_pkg::gen_state_t state_r, state_nxt;

  logic                  launch_r, launch_nxt;
  logic [1:0]            step_r, step_nxt;
  logic [INDEX_BITS-1:0] polar_index_r, polar_index_nxt;
  logic [INDEX_BITS-1:0] azimuth_index_r, azimuth_index_nxt;
  logic [INDEX_BITS-1:0] cur_pidx_r, cur_pidx_nxt;
  logic [INDEX_BITS-1:0] cur_aidx_r, cur_aidx_nxt;
  logic [ANGLE_BITS-1:0] pol_r, pol_nxt;
  logic [ANGLE_BITS-1:0] az_r, az_nxt;
  sgpg_pkg::sine_res_t   sp_r, sp_nxt;
  sgpg_pkg::sine_res_t   cp_r, cp_nxt;
  sgpg_pkg::sine_res_t   sa_r, sa_nxt;
  sgpg_pkg::sine_res_t   ca_r, ca_nxt;
  logic [RS_W-1:0]       rs_r, rs_nxt;
  logic signed [PW-1:0]  xs_r, xs_nxt;
  logic signed [PW-1:0]  ys_r, ys_nxt;
  logic signed [PW-1:0]  zs_r, zs_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [PW-1:0]  out_x_r, out_x_nxt;
  logic signed [PW-1:0]  out_y_r, out_y_nxt;
  logic signed [PW-1:0]  out_z_r, out_z_nxt;
  logic [sgpg_pkg::IDX_OUT_W-1:0] out_pidx_r, out_pidx_nxt;
  logic [sgpg_pkg::IDX_OUT_W-1:0] out_aidx_r, out_aidx_nxt;
  logic [SW-1:0]         polar_steps_r, azimuth_steps_r;
  logic [RW-1:0]         radius_r;

  logic                  accept;
  logic                  cfg_wr;
  logic [1:0]            cfg_idx;
  logic [SW-1:0]         ps_eff, as_eff;
  logic                  unit_done;
  logic                  out_free;

  logic                  div_start, div_done;
  logic [NUM_W-1:0]      div_num;
  logic [SW-1:0]         div_den;
  logic [ANGLE_BITS-1:0] div_quo;
  logic [SW-1:0]         div_rem;

  logic                  sine_start, sine_done;
  logic [ANGLE_BITS-1:0] sine_ang;
  sgpg_pkg::sine_res_t   sine_res;

  logic                  mul_start, mul_done;
  logic [RS_W-1:0]       mul_a;
  logic [MW-1:0]         mul_b;
  logic [SC_W-1:0]       mul_prod;

  logic [CMP_W-1:0]      pnext;
  logic                  pwrap;
  logic [SC_W-1:0]       rnd_xy, rnd_z;
  logic [PW-1:0]         mag_xy, mag_z;

  sgpg_div #(
    .NUM_W(NUM_W),
    .DEN_W(SW),
    .QUO_W(ANGLE_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  sgpg_sine #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_sine (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sine_start),
    .angle(sine_ang),
    .done (sine_done),
    .res  (sine_res)
  );

  sgpg_mul #(
    .A_W(RS_W),
    .B_W(MW)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  assign accept   = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = paddr[sgpg_pkg::CFG_ADDR_W-1:2];
  assign ps_eff   = (polar_steps_r == '0) ? SW'(1) : polar_steps_r;
  assign as_eff   = (azimuth_steps_r == '0) ? SW'(1) : azimuth_steps_r;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (state_r)
      sgpg_pkg::ST_DIV_POL,
      sgpg_pkg::ST_DIV_AZ,
      sgpg_pkg::ST_DIV_WRAP: unit_done = div_done;
      sgpg_pkg::ST_SINE:     unit_done = sine_done;
      sgpg_pkg::ST_SCALE:    unit_done = mul_done;
      default:               unit_done = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sgpg_pkg::ST_IDLE: begin
        if (accept) state_nxt = sgpg_pkg::ST_DIV_POL;
      end
      sgpg_pkg::ST_DIV_POL: begin
        if (div_done) state_nxt = sgpg_pkg::ST_DIV_AZ;
      end
      sgpg_pkg::ST_DIV_AZ: begin
        if (div_done) state_nxt = sgpg_pkg::ST_DIV_WRAP;
      end
      sgpg_pkg::ST_DIV_WRAP: begin
        if (div_done) state_nxt = sgpg_pkg::ST_SINE;
      end
      sgpg_pkg::ST_SINE: begin
        if (sine_done && step_r == 2'd3) state_nxt = sgpg_pkg::ST_SCALE;
      end
      sgpg_pkg::ST_SCALE: begin
        if (mul_done && step_r == 2'd3) state_nxt = sgpg_pkg::ST_OUT;
      end
      sgpg_pkg::ST_OUT: begin
        if (out_free) state_nxt = sgpg_pkg::ST_IDLE;
      end
      default: state_nxt = sgpg_pkg::ST_IDLE;
    endcase
  end

  // unit control and operand select
  always_comb begin
    in_ready   = (state_r == sgpg_pkg::ST_IDLE);
    div_start  = launch_r && (state_r inside {sgpg_pkg::ST_DIV_POL, sgpg_pkg::ST_DIV_AZ,
                                              sgpg_pkg::ST_DIV_WRAP});
    sine_start = launch_r && (state_r == sgpg_pkg::ST_SINE);
    mul_start  = launch_r && (state_r == sgpg_pkg::ST_SCALE);

    case (state_r)
      sgpg_pkg::ST_DIV_POL: begin
        div_num = (NUM_W'(cur_pidx_r) << (ANGLE_BITS - 1)) + NUM_W'(ps_eff[SW-1:1]);
        div_den = ps_eff;
      end
      sgpg_pkg::ST_DIV_AZ: begin
        div_num = (NUM_W'(cur_aidx_r) << ANGLE_BITS) + NUM_W'(as_eff[SW-1:1]);
        div_den = as_eff;
      end
      default: begin
        div_num = NUM_W'(cur_aidx_r) + NUM_W'(1);
        div_den = as_eff;
      end
    endcase

    case (step_r)
      2'd0:    sine_ang = pol_r;
      2'd1:    sine_ang = pol_r + ANG_QUARTER;
      2'd2:    sine_ang = az_r;
      default: sine_ang = az_r + ANG_QUARTER;
    endcase

    case (step_r)
      2'd0: begin
        mul_a = RS_W'(radius_r);
        mul_b = sp_r.mag;
      end
      2'd1: begin
        mul_a = rs_r;
        mul_b = ca_r.mag;
      end
      2'd2: begin
        mul_a = rs_r;
        mul_b = sa_r.mag;
      end
      default: begin
        mul_a = RS_W'(radius_r);
        mul_b = cp_r.mag;
      end
    endcase
  end

  // datapath
  always_comb begin
    pnext  = CMP_W'(cur_pidx_r) + CMP_W'(1);
    pwrap  = pnext > CMP_W'(ps_eff);
    rnd_xy = mul_prod + (SC_W'(1) << (sgpg_pkg::XY_SHIFT - 1));
    rnd_z  = mul_prod + (SC_W'(1) << (sgpg_pkg::Z_SHIFT - 1));
    mag_xy = rnd_xy[PW+sgpg_pkg::XY_SHIFT-1:sgpg_pkg::XY_SHIFT];
    mag_z  = rnd_z[PW+sgpg_pkg::Z_SHIFT-1:sgpg_pkg::Z_SHIFT];

    launch_nxt        = accept || (unit_done && state_nxt != sgpg_pkg::ST_OUT);
    step_nxt          = step_r;
    polar_index_nxt   = polar_index_r;
    azimuth_index_nxt = azimuth_index_r;
    cur_pidx_nxt      = cur_pidx_r;
    cur_aidx_nxt      = cur_aidx_r;
    pol_nxt           = pol_r;
    az_nxt            = az_r;
    sp_nxt            = sp_r;
    cp_nxt            = cp_r;
    sa_nxt            = sa_r;
    ca_nxt            = ca_r;
    rs_nxt            = rs_r;
    xs_nxt            = xs_r;
    ys_nxt            = ys_r;
    zs_nxt            = zs_r;

    if (accept) begin
      cur_pidx_nxt = in_restart ? '0 : polar_index_r;
      cur_aidx_nxt = in_restart ? '0 : azimuth_index_r;
      step_nxt     = 2'd0;
    end

    if (unit_done) begin
      case (state_r)
        sgpg_pkg::ST_DIV_POL: pol_nxt = div_quo;
        sgpg_pkg::ST_DIV_AZ:  az_nxt  = div_quo;
        sgpg_pkg::ST_DIV_WRAP: begin
          if (pwrap) begin
            polar_index_nxt   = '0;
            azimuth_index_nxt = INDEX_BITS'(div_rem);
          end else begin
            polar_index_nxt   = pnext[INDEX_BITS-1:0];
            azimuth_index_nxt = cur_aidx_r;
          end
        end
        sgpg_pkg::ST_SINE: begin
          case (step_r)
            2'd0:    sp_nxt = sine_res;
            2'd1:    cp_nxt = sine_res;
            2'd2:    sa_nxt = sine_res;
            default: ca_nxt = sine_res;
          endcase
          step_nxt = step_r + 2'd1;
        end
        sgpg_pkg::ST_SCALE: begin
          case (step_r)
            2'd0:    rs_nxt = mul_prod[RS_W-1:0];
            2'd1:    xs_nxt = (sp_r.neg ^ ca_r.neg) ? -$signed(mag_xy) : $signed(mag_xy);
            2'd2:    ys_nxt = (sp_r.neg ^ sa_r.neg) ? -$signed(mag_xy) : $signed(mag_xy);
            default: zs_nxt = cp_r.neg ? -$signed(mag_z) : $signed(mag_z);
          endcase
          step_nxt = step_r + 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_pidx_nxt  = out_pidx_r;
    out_aidx_nxt  = out_aidx_r;
    if (state_r == sgpg_pkg::ST_OUT && out_free) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = xs_r;
      out_y_nxt     = ys_r;
      out_z_nxt     = zs_r;
      out_pidx_nxt  = sgpg_pkg::IDX_OUT_W'(cur_pidx_r);
      out_aidx_nxt  = sgpg_pkg::IDX_OUT_W'(cur_aidx_r);
    end
  end

  always_comb begin
    case (cfg_idx)
      sgpg_pkg::REG_POLAR_STEPS:   prdata = sgpg_pkg::CFG_DATA_W'(polar_steps_r);
      sgpg_pkg::REG_AZIMUTH_STEPS: prdata = sgpg_pkg::CFG_DATA_W'(azimuth_steps_r);
      sgpg_pkg::REG_SPHERE_RADIUS: prdata = sgpg_pkg::CFG_DATA_W'(radius_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= sgpg_pkg::ST_IDLE;
      launch_r        <= 1'b0;
      step_r          <= '0;
      polar_index_r   <= '0;
      azimuth_index_r <= '0;
      out_valid_r     <= 1'b0;
      polar_steps_r   <= sgpg_pkg::POLAR_STEPS_RST;
      azimuth_steps_r <= sgpg_pkg::AZIMUTH_STEPS_RST;
      radius_r        <= sgpg_pkg::SPHERE_RADIUS_RST;
    end else begin
      state_r         <= state_nxt;
      launch_r        <= launch_nxt;
      step_r          <= step_nxt;
      polar_index_r   <= polar_index_nxt;
      azimuth_index_r <= azimuth_index_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          sgpg_pkg::REG_POLAR_STEPS:   polar_steps_r   <= pwdata[SW-1:0];
          sgpg_pkg::REG_AZIMUTH_STEPS: azimuth_steps_r <= pwdata[SW-1:0];
          sgpg_pkg::REG_SPHERE_RADIUS: radius_r        <= pwdata[RW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_pidx_r <= cur_pidx_nxt;
    cur_aidx_r <= cur_aidx_nxt;
    pol_r      <= pol_nxt;
    az_r       <= az_nxt;
    sp_r       <= sp_nxt;
    cp_r       <= cp_nxt;
    sa_r       <= sa_nxt;
    ca_r       <= ca_nxt;
    rs_r       <= rs_nxt;
    xs_r       <= xs_nxt;
    ys_r       <= ys_nxt;
    zs_r       <= zs_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_z_r    <= out_z_nxt;
    out_pidx_r <= out_pidx_nxt;
    out_aidx_r <= out_aidx_nxt;
  end

  assign pready                = 1'b1;
  assign out_valid             = out_valid_r;
  assign out_x_pos             = out_x_r;
  assign out_y_pos             = out_y_r;
  assign out_z_pos             = out_z_r;
  assign out_polar_index_out   = out_pidx_r;
  assign out_azimuth_index_out = out_aidx_r;

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> div_start)
    else $error("request accepted but divider not started");

  a_single_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({div_done, sine_done, mul_done}))
    else $error("more than one unit finished in the same cycle");

  a_polar_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (div_done && state_r == sgpg_pkg::ST_DIV_WRAP)
      |=> (CMP_W'(polar_index_r) <= CMP_W'($past(ps_eff))))
    else $error("polar index advanced past polar_steps");

  a_out_load_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> $past(state_r == sgpg_pkg::ST_OUT))
    else $error("output loaded outside the output state");

endmodule

[tb/sphere_grid_point_generator_tb.sv]
module sphere_grid_point_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 400;
  localparam int LONG_HOLD     = 2500;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 120;
  localparam int HOLD_PHASE    = 2;
  localparam int PAUSE_PHASE   = 4;
  localparam int MAX_REPORTS   = 50;
  localparam int SCRIPT_LEN    = 38;

  typedef struct packed {
    logic signed [sgpg_pkg::POS_W-1:0] x;
    logic signed [sgpg_pkg::POS_W-1:0] y;
    logic signed [sgpg_pkg::POS_W-1:0] z;
    logic [sgpg_pkg::IDX_OUT_W-1:0]    pol_idx;
    logic [sgpg_pkg::IDX_OUT_W-1:0]    az_idx;
  } grid_point_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_REQ_CHECKED, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    grid_point_t want;
  } script_row_t;

  localparam logic signed [sgpg_pkg::POS_W-1:0] ZERO  = '0;
  localparam logic signed [sgpg_pkg::POS_W-1:0] EARTH = 25'sd6371000;
  localparam logic signed [sgpg_pkg::POS_W-1:0] R_TOP = 25'sd16777215;
  localparam grid_point_t NO_POINT = '0;

  // Q30 terms of the degree-9 sine series over a quarter turn
  localparam bit [63:0] SINE_COEF [5] = '{
    64'd1686629713, 64'd693598669, 64'd85569305, 64'd5026995, 64'd172272
  };

  // after reset, poles, equator quadrants, zero steps and radius, index past range
  localparam script_row_t DIRECTED_ROWS [SCRIPT_LEN] = '{
    '{ROW_REQ_CHECKED, 2'd0, 32'd0, '{ZERO, ZERO, EARTH, 10'd0, 10'd0}},
    '{ROW_REQ, 2'd0, 32'd0, NO_POINT},
    '{ROW_REQ, 2'd0, 32'd0, NO_POINT},
    '{ROW_REQ_CHECKED, 2'd0, 32'd1, '{ZERO, ZERO, EARTH, 10'd0, 10'd0}},
    '{ROW_REQ, 2'd0, 32'd0, NO_POINT},
    '{ROW_CFG, sgpg_pkg::REG_POLAR_STEPS, 32'd1, NO_POINT},
    '{ROW_CFG, sgpg_pkg::REG_AZIMUTH_STEPS, 32'd1, NO_POINT},
    '{ROW_CFG, sgpg_pkg::REG_SPHERE_RADIUS, 32'd16777215, NO_POINT},
    '{ROW_REQ_CHECKED, 2'd0, 32'd1, '{ZERO, ZERO, R_TOP, 10'd0, 10'd0}},
    '{ROW_REQ_CHECKED, 2'd0, 32'd0, '{ZERO, ZERO, -R_TOP, 10'd1, 10'd0}},
    '{ROW_REQ_CHECKED, 2'd0, 32'd0, '{ZERO, ZERO, R_TOP, 10'd0, 10'd0}},
    '{ROW_CFG, sgpg_pkg::REG_POLAR_STEPS, 32'd2, NO_POINT},
    '{ROW_CFG, sgpg_pkg::REG_AZIMUTH_STEPS, 32'd4, NO_POINT},
    '{ROW_REQ_CHECKED, 2'd0, 32'd1, '{ZERO, ZERO, R_TOP, 10'd0, 10'd0}},
    '{ROW_REQ_CHECKED, 2'd0, 32'd0, '{R_TOP, ZERO, ZERO, 10'd1, 10'd0}},
    '{ROW_REQ_CHECKED, 2'd0, 32'd0, '{ZERO, ZERO, -R_TOP, 10'd2, 10'd0}},
    '{ROW_REQ, 2'd0, 32'd0, NO_POINT},
    '{ROW_REQ_CHECKED, 2'd0, 32'd0, '{ZERO, R_TOP, ZERO, 10'd1, 10'd1}},
    '{ROW_REQ, 2'd0, 32'd0, NO_POINT},
    '{ROW_REQ, 2'd0, 32'd0, NO_POINT},
    '{ROW_REQ_CHECKED, 2'd0, 32'd0, '{-R_TOP, ZERO, ZERO, 10'd1, 10'd2}},
    '{ROW_REQ, 2'd0, 32'd0, NO_POINT},
    '{ROW_CFG, sgpg_pkg::REG_POLAR_STEPS, 32'd0, NO_POINT},
    '{ROW_CFG, sgpg_pkg::REG_AZIMUTH_STEPS, 32'd0, NO_POINT},
    '{ROW_CFG, sgpg_pkg::REG_SPHERE_RADIUS, 32'd0, NO_POINT},
    '{ROW_REQ_CHECKED, 2'd0, 32'd0, '{ZERO, ZERO, ZERO, 10'd0, 10'd3}},
    '{ROW_REQ_CHECKED, 2'd0, 32'd0, '{ZERO, ZERO, ZERO, 10'd1, 10'd3}},
    '{ROW_REQ_CHECKED, 2'd0, 32'd0, '{ZERO, ZERO, ZERO, 10'd0, 10'd0}},
    '{ROW_CFG, sgpg_pkg::REG_POLAR_STEPS, 32'd1023, NO_POINT},
    '{ROW_CFG, sgpg_pkg::REG_AZIMUTH_STEPS, 32'd1023, NO_POINT},
    '{ROW_CFG, sgpg_pkg::REG_SPHERE_RADIUS, 32'd6371000, NO_POINT},
    '{ROW_REQ, 2'd0, 32'd1, NO_POINT},
    '{ROW_REQ, 2'd0, 32'd0, NO_POINT},
    '{ROW_REQ, 2'd0, 32'd0, NO_POINT},
    '{ROW_REQ, 2'd0, 32'd0, NO_POINT},
    '{ROW_CFG, sgpg_pkg::REG_POLAR_STEPS, 32'd2, NO_POINT},
    '{ROW_REQ, 2'd0, 32'd0, NO_POINT},
    '{ROW_REQ, 2'd0, 32'd0, NO_POINT}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_restart = 1'b0;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sgpg_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [sgpg_pkg::CFG_DATA_W-1:0] pwdata = '0;

  logic                              in_ready;
  logic                              out_valid;
  logic signed [sgpg_pkg::POS_W-1:0] out_x_pos;
  logic signed [sgpg_pkg::POS_W-1:0] out_y_pos;
  logic signed [sgpg_pkg::POS_W-1:0] out_z_pos;
  logic [sgpg_pkg::IDX_OUT_W-1:0]    out_polar_index_out;
  logic [sgpg_pkg::IDX_OUT_W-1:0]    out_azimuth_index_out;
  logic [sgpg_pkg::CFG_DATA_W-1:0]   prdata;
  logic                              pready;

  grid_point_t pending_points [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          src_burst = 1'b0;
  bit          sink_burst = 1'b0;
  bit          hold_results = 1'b0;

  bit [9:0]  set_polar_steps = sgpg_pkg::POLAR_STEPS_RST;
  bit [9:0]  set_azimuth_steps = sgpg_pkg::AZIMUTH_STEPS_RST;
  bit [23:0] set_radius = sgpg_pkg::SPHERE_RADIUS_RST;
  bit [9:0]  grid_pol = '0;
  bit [9:0]  grid_az = '0;

  sphere_grid_point_generator dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_restart            (in_restart),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_x_pos             (out_x_pos),
    .out_y_pos             (out_y_pos),
    .out_z_pos             (out_z_pos),
    .out_polar_index_out   (out_polar_index_out),
    .out_azimuth_index_out (out_azimuth_index_out),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // {negative, magnitude 0..32768} of a 16-bit turn fraction
  function automatic bit [16:0] turn_sine(input bit [15:0] angle);
    bit [63:0] z, z2, t, s, m;
    z = 64'(angle[13:0]) << 16;
    if (angle[14]) z = (64'd1 << 30) - z;
    z2 = (z * z) >> 30;
    t = SINE_COEF[4];
    for (int k = 3; k >= 0; k--) t = SINE_COEF[k] - ((z2 * t) >> 30);
    s = (z * t) >> 30;
    m = (s + 64'd16384) >> 15;
    if (m > 64'd32768) m = 64'd32768;
    return {angle[15], m[15:0]};
  endfunction

  function automatic logic signed [sgpg_pkg::POS_W-1:0] signed_metres(input bit [63:0] mag,
                                                                      input bit neg);
    return neg ? -$signed(mag[sgpg_pkg::POS_W-1:0]) : $signed(mag[sgpg_pkg::POS_W-1:0]);
  endfunction

  function automatic grid_point_t next_grid_point(input logic restart);
    grid_point_t p;
    bit [63:0] pol_div, az_div, pol, az, r;
    bit [16:0] sp, cp, sa, ca;
    pol_div = (set_polar_steps == 0) ? 64'd1 : 64'(set_polar_steps);
    az_div = (set_azimuth_steps == 0) ? 64'd1 : 64'(set_azimuth_steps);
    r = 64'(set_radius);
    if (restart) begin
      grid_pol = '0;
      grid_az = '0;
    end
    pol = ((64'(grid_pol) << 15) + pol_div / 2) / pol_div;
    az = ((64'(grid_az) << 16) + az_div / 2) / az_div;
    sp = turn_sine(pol[15:0]);
    cp = turn_sine(pol[15:0] + 16'h4000);
    sa = turn_sine(az[15:0]);
    ca = turn_sine(az[15:0] + 16'h4000);
    p.x = signed_metres((r * sp[15:0] * ca[15:0] + (64'd1 << 29)) >> 30, sp[16] ^ ca[16]);
    p.y = signed_metres((r * sp[15:0] * sa[15:0] + (64'd1 << 29)) >> 30, sp[16] ^ sa[16]);
    p.z = signed_metres((r * cp[15:0] + (64'd1 << 14)) >> 15, cp[16]);
    p.pol_idx = grid_pol;
    p.az_idx = grid_az;
    if (64'(grid_pol) + 64'd1 > pol_div) begin
      grid_pol = '0;
      grid_az = 10'((64'(grid_az) + 64'd1) % az_div);
    end else begin
      grid_pol = grid_pol + 10'd1;
    end
    return p;
  endfunction

  function automatic logic [31:0] pick_steps();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v[9:0] = '0;
      1: v[9:0] = 10'd1023;
      2: v[9:0] = 10'($urandom_range(1, 1023));
      default: v[9:0] = 10'($urandom_range(1, 16));
    endcase
    return v;
  endfunction

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic check_point(input grid_point_t got);
    grid_point_t want;
    if (pending_points.size() == 0) begin
      report_error($sformatf("unexpected point x=%0d y=%0d z=%0d", got.x, got.y, got.z));
      return;
    end
    want = pending_points.pop_front();
    if (got.x !== want.x)
      report_error($sformatf("x_pos got %0d expected %0d", got.x, want.x));
    if (got.y !== want.y)
      report_error($sformatf("y_pos got %0d expected %0d", got.y, want.y));
    if (got.z !== want.z)
      report_error($sformatf("z_pos got %0d expected %0d", got.z, want.z));
    if (got.pol_idx !== want.pol_idx)
      report_error($sformatf("polar index got %0d expected %0d", got.pol_idx, want.pol_idx));
    if (got.az_idx !== want.az_idx)
      report_error($sformatf("azimuth index got %0d expected %0d", got.az_idx, want.az_idx));
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      sgpg_pkg::REG_POLAR_STEPS:   set_polar_steps = value[9:0];
      sgpg_pkg::REG_AZIMUTH_STEPS: set_azimuth_steps = value[9:0];
      sgpg_pkg::REG_SPHERE_RADIUS: set_radius = value[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_request(input logic restart, input bit use_table,
                              input grid_point_t table_point);
    grid_point_t p;
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_restart <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_ready !== 1'b1);
    p = next_grid_point(restart);
    pending_points.push_back(use_table ? table_point : p);
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sphere_grid_point_generator_tb failed");
    $finish;
  end

  initial begin : point_sink
    int stall;
    grid_point_t got;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = sink_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{out_x_pos, out_y_pos, out_z_pos, out_polar_index_out, out_azimuth_index_out};
      check_point(got);
    end
  end

  initial begin : stimulus
    script_row_t row;
    logic [31:0] radius_word;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      case (row.kind)
        ROW_CFG: begin
          in_valid <= 1'b0;
          wait_drained();
          write_reg(row.reg_idx, row.value);
        end
        ROW_REQ: send_request(row.value[0], 1'b0, NO_POINT);
        default: send_request(row.value[0], 1'b1, row.want);
      endcase
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_drained();
      write_reg(sgpg_pkg::REG_POLAR_STEPS, pick_steps());
      write_reg(sgpg_pkg::REG_AZIMUTH_STEPS, pick_steps());
      radius_word = $urandom;
      case ($urandom_range(0, 5))
        0: radius_word[23:0] = '0;
        1: radius_word[23:0] = '1;
        default: ;
      endcase
      write_reg(sgpg_pkg::REG_SPHERE_RADIUS, radius_word);
      src_burst = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);
      if (ph == HOLD_PHASE) hold_results = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_request($urandom_range(0, 19) == 0, 1'b0, NO_POINT);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("sphere_grid_point_generator_tb passed");
    else
      $display("sphere_grid_point_generator_tb failed");
    $finish;
  end

endmodule
